[hw/rtl/fsq_pkg.sv]
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared sizes, operation codes and register indexes of the frame slot queue.
// ----------------------------------------------------------------------------
package fsq_pkg;

    // Ring geometry.
    localparam int MAX_SLOTS      = 16;
    localparam int MAX_SLOT_BYTES = 256;

    // Index widths into the ring and into one slot.
    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int OFS_W   = $clog2(MAX_SLOT_BYTES);
    localparam int ADDR_W  = SLOT_W + OFS_W;
    localparam int STORE_DEPTH = MAX_SLOTS * MAX_SLOT_BYTES;

    // Field widths of the interface.
    localparam int CFG_SLOTS_W = 5;
    localparam int LEN_W       = 9;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 5;
    localparam int DROP_W      = 32;

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - (LEN_W + BYTE_W + PEND_W + DROP_W);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Operation codes carried on s_tuser.
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PEEK = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // Register indexes, taken from paddr[2].
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic REG_SLOT_BYTES   = 1'b1;

endpackage

[hw/rtl/frame_slot_queue.sv]
// ----------------------------------------------------------------------------
// frame_slot_queue
// Ring of fixed-size frame slots with a length table, fed one byte per
// transfer, with peek and pop access to the head frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_        in         tuser: operation; tdata: data_byte, byte_offset;
//                       tlast: frame_last
//  m_        out        tuser: accepted; tdata: head_length, head_byte,
//                       pending_count, dropped_count
//  APB       in/out     reg 0 slots_in_use at 0x0, reg 1 slot_bytes at 0x4
//
//  The state update and the frame store access of an item both happen at its
//  transfer edge; the result fields wait in the middle stage, and the output
//  register joins them with the registered read data when the middle stage
//  moves on. A new item is taken every cycle while results drain, since
//  each item needs at most one frame store access: a push writes, a peek reads.
//  Reset clears the control state and the length table and holds s_tready
//  low; the frame store needs no clearing. A stalled result holds the middle
//  stage, which then holds the input.
// ----------------------------------------------------------------------------
module frame_slot_queue (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] data_byte, [15:8] byte_offset
    input  logic [fsq_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tlast,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [8:0] head_length, [16:9] head_byte, [21:17] pending_count,
    // [53:22] dropped_count, [55:54] zero
    output logic [fsq_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] accepted
    output logic                              m_tuser,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [fsq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fsq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int SLOT_W = fsq_pkg::SLOT_W;
    localparam int OFS_W  = fsq_pkg::OFS_W;
    localparam int LEN_W  = fsq_pkg::LEN_W;
    localparam int CSW    = fsq_pkg::CFG_SLOTS_W;
    localparam int PEND_W = fsq_pkg::PEND_W;
    localparam int DROP_W = fsq_pkg::DROP_W;
    localparam int BYTE_W = fsq_pkg::BYTE_W;

    localparam logic [CSW-1:0]   SLOTS_MAX = CSW'(fsq_pkg::MAX_SLOTS);
    localparam logic [LEN_W-1:0] BYTES_MAX = LEN_W'(fsq_pkg::MAX_SLOT_BYTES);

    // Configuration registers.
    logic [CSW-1:0]    slots_in_use_reg;
    logic [LEN_W-1:0]  slot_bytes_reg;
    logic [CSW-1:0]    eff_slots;
    logic [LEN_W-1:0]  eff_bytes;

    // Queue state.
    logic [LEN_W-1:0]  len_reg  [fsq_pkg::MAX_SLOTS];
    logic [LEN_W-1:0]  len_next [fsq_pkg::MAX_SLOTS];
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              reserved_reg, reserved_next;
    logic [LEN_W-1:0]  wpos_reg, wpos_next;
    logic              dropping_reg, dropping_next;
    logic [DROP_W-1:0] drop_cnt_reg, drop_cnt_next;

    // Middle stage: result fields waiting for the store read.
    logic              p_valid_reg;
    logic              p_acc_reg;
    logic              p_byte_en_reg;
    logic [LEN_W-1:0]  p_hlen_reg;
    logic [PEND_W-1:0] p_pend_reg;
    logic [DROP_W-1:0] p_drop_reg;

    // Output register.
    logic              m_valid_reg;
    logic              m_acc_reg;
    logic [fsq_pkg::M_TDATA_W-1:0] m_data_reg;

    // Item decode and results of the current item.
    fsq_pkg::op_t      op;
    logic [BYTE_W-1:0] in_byte;
    logic [OFS_W-1:0]  in_offset;
    logic              in_fire;
    logic              p_move;
    logic              acc;
    logic              byte_en;
    logic [LEN_W-1:0]  hlen;

    // Frame store access.
    logic                         mem_we;
    logic                         mem_re;
    logic [fsq_pkg::ADDR_W-1:0]   mem_addr;
    logic [BYTE_W-1:0]            mem_rdata;

    logic cfg_write;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                    input logic [CSW-1:0] count);
        logic [CSW-1:0] n;
        n = CSW'(idx) + CSW'(1);
        return (n >= count) ? '0 : SLOT_W'(n);
    endfunction

    assign op        = fsq_pkg::op_t'(s_tuser);
    assign in_byte   = s_tdata[BYTE_W-1:0];
    assign in_offset = s_tdata[BYTE_W+OFS_W-1:BYTE_W];

    // Register values clamped into their legal range.
    assign eff_slots = (slots_in_use_reg == '0) ? CSW'(1) :
                       (slots_in_use_reg > SLOTS_MAX) ? SLOTS_MAX : slots_in_use_reg;
    assign eff_bytes = (slot_bytes_reg == '0) ? LEN_W'(1) :
                       (slot_bytes_reg > BYTES_MAX) ? BYTES_MAX : slot_bytes_reg;

    // Handshake: the middle stage drains into the output register.
    assign p_move   = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = aresetn && (!p_valid_reg || p_move);
    assign in_fire  = s_tvalid && s_tready;

    // State update for one item.
    always_comb begin
        len_next       = len_reg;
        wslot_next     = wslot_reg;
        rslot_next     = rslot_reg;
        pend_next      = pend_reg;
        reserved_next  = reserved_reg;
        wpos_next      = wpos_reg;
        dropping_next  = dropping_reg;
        drop_cnt_next  = drop_cnt_reg;
        acc            = 1'b0;
        byte_en        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = {rslot_reg, in_offset};

        if (in_fire) begin
            case (op)
                fsq_pkg::OP_PUSH: begin
                    // First byte of a frame: reserve a slot or drop the frame.
                    if (!reserved_reg && !dropping_reg) begin
                        if (pend_reg >= PEND_W'(eff_slots)) begin
                            drop_cnt_next = drop_cnt_reg + DROP_W'(1);
                            dropping_next = 1'b1;
                        end else begin
                            reserved_next = 1'b1;
                            wpos_next     = '0;
                        end
                    end
                    if (reserved_next) begin
                        // Store the byte unless the slot is already full.
                        if (wpos_next < eff_bytes) begin
                            mem_we    = 1'b1;
                            mem_addr  = {wslot_reg, wpos_next[OFS_W-1:0]};
                            wpos_next = wpos_next + LEN_W'(1);
                        end
                        if (s_tlast) begin
                            len_next[wslot_reg] = wpos_next;
                            wslot_next    = next_slot(wslot_reg, eff_slots);
                            pend_next     = pend_reg + PEND_W'(1);
                            reserved_next = 1'b0;
                            wpos_next     = '0;
                            acc           = 1'b1;
                        end
                    end else if (s_tlast) begin
                        dropping_next = 1'b0;
                    end
                end
                fsq_pkg::OP_PEEK: begin
                    if (pend_reg != '0) begin
                        acc     = 1'b1;
                        mem_re  = 1'b1;
                        byte_en = LEN_W'(in_offset) < len_reg[rslot_reg];
                    end
                end
                fsq_pkg::OP_POP: begin
                    if (pend_reg != '0) begin
                        acc                 = 1'b1;
                        len_next[rslot_reg] = '0;
                        rslot_next          = next_slot(rslot_reg, eff_slots);
                        pend_next           = pend_reg - PEND_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end

        hlen = (pend_next != '0) ? len_next[rslot_next] : '0;
    end

    // Queue state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fsq_pkg::MAX_SLOTS; i++) begin
                len_reg[i] <= '0;
            end
            wslot_reg    <= '0;
            rslot_reg    <= '0;
            pend_reg     <= '0;
            reserved_reg <= 1'b0;
            wpos_reg     <= '0;
            dropping_reg <= 1'b0;
            drop_cnt_reg <= '0;
        end else begin
            len_reg      <= len_next;
            wslot_reg    <= wslot_next;
            rslot_reg    <= rslot_next;
            pend_reg     <= pend_next;
            reserved_reg <= reserved_next;
            wpos_reg     <= wpos_next;
            dropping_reg <= dropping_next;
            drop_cnt_reg <= drop_cnt_next;
        end
    end

    // Middle stage: control bit under reset, payload loaded on each transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (in_fire) begin
            p_valid_reg <= 1'b1;
        end else if (p_move) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p_acc_reg     <= acc;
            p_byte_en_reg <= byte_en;
            p_hlen_reg    <= hlen;
            p_pend_reg    <= pend_next;
            p_drop_reg    <= drop_cnt_next;
        end
    end

    // Output register: joins the store read data with the status fields.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move) begin
            m_acc_reg  <= p_acc_reg;
            m_data_reg <= {{fsq_pkg::M_PAD_W{1'b0}}, p_drop_reg, p_pend_reg,
                           (p_byte_en_reg ? mem_rdata : {BYTE_W{1'b0}}), p_hlen_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_acc_reg;

    fsq_frame_ram u_frame_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .rd_en   (mem_re),
        .addr    (mem_addr),
        .wr_data (in_byte),
        .rd_data (mem_rdata)
    );

    // Configuration port: writes land in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= SLOTS_MAX;
            slot_bytes_reg   <= BYTES_MAX;
        end else if (cfg_write) begin
            unique case (paddr[2])
                fsq_pkg::REG_SLOTS_IN_USE: slots_in_use_reg <= pwdata[CSW-1:0];
                fsq_pkg::REG_SLOT_BYTES:   slot_bytes_reg   <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fsq_pkg::REG_SLOTS_IN_USE:
                prdata = {{(fsq_pkg::APB_DATA_W-CSW){1'b0}}, slots_in_use_reg};
            fsq_pkg::REG_SLOT_BYTES:
                prdata = {{(fsq_pkg::APB_DATA_W-LEN_W){1'b0}}, slot_bytes_reg};
            default:
                prdata = '0;
        endcase
    end

endmodule

[hw/rtl/fsq_frame_ram.sv]
// ----------------------------------------------------------------------------
// fsq_frame_ram
// Single-port frame byte store with a registered read port.
// ----------------------------------------------------------------------------
module fsq_frame_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic                         rd_en,
    input  logic [fsq_pkg::ADDR_W-1:0]   addr,
    input  logic [fsq_pkg::BYTE_W-1:0]   wr_data,
    output logic [fsq_pkg::BYTE_W-1:0]   rd_data
);

    logic [fsq_pkg::BYTE_W-1:0] mem [fsq_pkg::STORE_DEPTH];
    logic [fsq_pkg::BYTE_W-1:0] rd_data_reg;

    // Write and registered read; read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for frame_slot_queue. A short table of directed
// transfers covers the empty ring, unknown operations, truncated and dropped
// frames and clamped register values. Random frame traffic follows in three
// phases with different register settings and idle patterns on both
// channels. Every result transfer is checked field by field against a
// shadow copy of the queue state, or against a status given up front.
// ----------------------------------------------------------------------------
module tb;

    localparam int LEN_W  = fsq_pkg::LEN_W;
    localparam int BYTE_W = fsq_pkg::BYTE_W;
    localparam int PEND_W = fsq_pkg::PEND_W;
    localparam int DROP_W = fsq_pkg::DROP_W;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 520;

    // One result transfer: tuser bit first, then the tdata fields from the lowest up.
    typedef struct packed {
        logic              accepted;
        logic [LEN_W-1:0]  head_length;
        logic [BYTE_W-1:0] head_byte;
        logic [PEND_W-1:0] pending;
        logic [DROP_W-1:0] dropped;
    } frame_status_t;

    // One input transfer, optionally carrying a status that is known up front.
    typedef struct {
        logic [1:0]    op;
        logic [7:0]    data;
        logic          last;
        logic [7:0]    offset;
        bit            fixed;
        frame_status_t fixed_status;
    } queue_op_t;

    typedef struct {
        bit          is_write;
        logic        reg_index;
        logic [31:0] value;
        queue_op_t   xfer;
    } stim_row_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [fsq_pkg::S_TDATA_W-1:0]    s_tdata  = '0;
    logic [1:0]                       s_tuser  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [fsq_pkg::M_TDATA_W-1:0]    m_tdata;
    logic                             m_tuser;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [fsq_pkg::APB_ADDR_W-1:0]   paddr    = '0;
    logic [fsq_pkg::APB_DATA_W-1:0]   pwdata   = '0;
    logic [fsq_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;

    // Shadow copy of the queue and its registers.
    logic [7:0]       shadow_store [fsq_pkg::STORE_DEPTH];
    logic [LEN_W-1:0] shadow_len [fsq_pkg::MAX_SLOTS];
    int unsigned      fill_slot   = 0;
    int unsigned      head_slot   = 0;
    int unsigned      frames_held = 0;
    int unsigned      fill_pos    = 0;
    bit               filling     = 1'b0;
    bit               discarding  = 1'b0;
    logic [31:0]      drop_total  = '0;
    logic [4:0]       slots_reg   = 5'd16;
    logic [8:0]       bytes_reg   = 9'd256;

    queue_op_t     offered_q [$];
    frame_status_t status_q [$];

    int errors        = 0;
    int idle_cycles   = 0;
    int sent_count    = 0;
    int send_idle_pct = 18;
    int recv_idle_pct = 82;

    frame_slot_queue i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Register values are clamped to the legal range when they are used.
    function automatic int unsigned ring_slots();
        if (slots_reg < 1) return 1;
        if (slots_reg > fsq_pkg::MAX_SLOTS) return fsq_pkg::MAX_SLOTS;
        return slots_reg;
    endfunction

    function automatic int unsigned slot_cap();
        if (bytes_reg < 1) return 1;
        if (bytes_reg > fsq_pkg::MAX_SLOT_BYTES) return fsq_pkg::MAX_SLOT_BYTES;
        return bytes_reg;
    endfunction

    function automatic int unsigned next_ring_slot(int unsigned idx);
        return (idx + 1 >= ring_slots()) ? 0 : idx + 1;
    endfunction

    // Advances the shadow queue by one input transfer and returns its status.
    function automatic frame_status_t apply_op(queue_op_t x);
        frame_status_t r;
        int unsigned   ws;
        int unsigned   rs;
        r = '0;
        case (x.op)
            fsq_pkg::OP_PUSH: begin
                // The first byte of a frame either reserves a slot or dooms it.
                if (!filling && !discarding) begin
                    if (frames_held >= ring_slots()) begin
                        drop_total = drop_total + 1;
                        discarding = 1'b1;
                    end else begin
                        filling  = 1'b1;
                        fill_pos = 0;
                    end
                end
                if (filling) begin
                    ws = fill_slot % fsq_pkg::MAX_SLOTS;
                    if (fill_pos < slot_cap()) begin
                        shadow_store[ws * fsq_pkg::MAX_SLOT_BYTES + fill_pos] = x.data;
                        fill_pos++;
                    end
                    if (x.last) begin
                        shadow_len[ws] = LEN_W'(fill_pos);
                        fill_slot      = next_ring_slot(ws);
                        frames_held++;
                        filling        = 1'b0;
                        fill_pos       = 0;
                        r.accepted     = 1'b1;
                    end
                end else if (x.last) begin
                    discarding = 1'b0;
                end
            end
            fsq_pkg::OP_PEEK: begin
                if (frames_held != 0) begin
                    rs         = head_slot % fsq_pkg::MAX_SLOTS;
                    r.accepted = 1'b1;
                    if (x.offset < shadow_len[rs])
                        r.head_byte = shadow_store[rs * fsq_pkg::MAX_SLOT_BYTES + x.offset];
                end
            end
            fsq_pkg::OP_POP: begin
                if (frames_held != 0) begin
                    rs             = head_slot % fsq_pkg::MAX_SLOTS;
                    r.accepted     = 1'b1;
                    shadow_len[rs] = '0;
                    head_slot      = next_ring_slot(rs);
                    frames_held--;
                end
            end
            default: ;
        endcase
        if (frames_held != 0)
            r.head_length = shadow_len[head_slot % fsq_pkg::MAX_SLOTS];
        r.pending = PEND_W'(frames_held);
        r.dropped = drop_total;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Input transfers feed the shadow queue, result transfers are checked,
    // register writes update the shadow registers.
    always @(posedge aclk) begin
        queue_op_t     op_in;
        frame_status_t predicted;
        frame_status_t want;
        frame_status_t got;
        if (aresetn && s_tvalid && s_tready) begin
            op_in     = offered_q.pop_front();
            predicted = apply_op(op_in);
            status_q.push_back(op_in.fixed ? op_in.fixed_status : predicted);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[8:0], m_tdata[16:9], m_tdata[21:17], m_tdata[53:22]};
            if (status_q.size() == 0) begin
                $display("%0t ns: result transfer with nothing expected, got %0h",
                         $time, got);
                errors++;
            end else begin
                want = status_q.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(got.accepted));
                check_field("head_length", 32'(want.head_length), 32'(got.head_length));
                check_field("head_byte", 32'(want.head_byte), 32'(got.head_byte));
                check_field("pending_count", 32'(want.pending), 32'(got.pending));
                check_field("dropped_count", want.dropped, got.dropped);
            end
        end
        if (psel && penable && pwrite && pready) begin
            if (paddr[2] == fsq_pkg::REG_SLOTS_IN_USE)
                slots_reg = pwdata[4:0];
            else
                bytes_reg = pwdata[8:0];
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic queue_op_t make_op(logic [1:0] op, logic [7:0] data, logic last,
                                          logic [7:0] offset);
        queue_op_t x;
        x.op           = op;
        x.data         = data;
        x.last         = last;
        x.offset       = offset;
        x.fixed        = 1'b0;
        x.fixed_status = '0;
        return x;
    endfunction

    function automatic stim_row_t op_row(logic [1:0] op, logic [7:0] data, logic last,
                                         logic [7:0] offset);
        stim_row_t row;
        row.is_write  = 1'b0;
        row.reg_index = 1'b0;
        row.value     = '0;
        row.xfer      = make_op(op, data, last, offset);
        return row;
    endfunction

    // Row whose status can be read off directly.
    function automatic stim_row_t fixed_row(logic [1:0] op, logic [7:0] data, logic last,
                                            logic [7:0] offset, logic acc, int hlen,
                                            int hbyte, int pend, int drop);
        stim_row_t row;
        row                   = op_row(op, data, last, offset);
        row.xfer.fixed        = 1'b1;
        row.xfer.fixed_status = {acc, LEN_W'(hlen), BYTE_W'(hbyte), PEND_W'(pend),
                                 DROP_W'(drop)};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic reg_index, logic [31:0] value);
        stim_row_t row;
        row           = op_row(fsq_pkg::OP_PUSH, '0, 1'b0, '0);
        row.is_write  = 1'b1;
        row.reg_index = reg_index;
        row.value     = value;
        return row;
    endfunction

    // Offers one input transfer, with an optional random gap before it.
    task automatic send_item(queue_op_t x);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        offered_q.push_back(x);
        s_tvalid <= 1'b1;
        s_tuser  <= x.op;
        s_tlast  <= x.last;
        s_tdata  <= {x.offset, x.data};
        do @(posedge aclk); while (!s_tready);
        if (x.op != OP_UNKNOWN)
            sent_count++;
    endtask

    // Holds the input until every expected result has come back.
    task automatic await_results();
        s_tvalid <= 1'b0;
        while (offered_q.size() != 0 || status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic reg_index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Closes any open frame and pops every held frame so that a register
    // change never meets a frame in flight.
    task automatic empty_ring();
        int unsigned n;
        await_results();
        if (filling || discarding) begin
            send_item(make_op(fsq_pkg::OP_PUSH, 8'($urandom_range(255)), 1'b1, '0));
            await_results();
        end
        n = frames_held;
        repeat (n) send_item(make_op(fsq_pkg::OP_POP, 8'($urandom_range(255)), 1'b0, '0));
        await_results();
    endtask

    function automatic logic [7:0] pick_offset();
        return ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    endfunction

    // Mostly short frames, some up to 40 bytes or just past the slot size, a rare one past it.
    function automatic int unsigned pick_length();
        int unsigned r;
        int unsigned top;
        r   = $urandom_range(99);
        top = (slot_cap() + 2 < 40) ? slot_cap() + 2 : 40;
        if (r < 85) return $urandom_range(6, 1);
        if (r < 99) return $urandom_range(top, 1);
        return slot_cap() + $urandom_range(3, 1);
    endfunction

    // A whole frame, with the odd peek or pop slipped between its bytes.
    task automatic send_frame(int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8)
                send_item(make_op($urandom_range(1) ? fsq_pkg::OP_PEEK : fsq_pkg::OP_POP,
                                  8'($urandom_range(255)), 1'($urandom_range(1)),
                                  pick_offset()));
            send_item(make_op(fsq_pkg::OP_PUSH, 8'($urandom_range(255)), i == len - 1,
                              8'($urandom_range(255))));
        end
    endtask

    // Random traffic; the push share drifts so the ring both fills and empties.
    task automatic run_traffic(int unsigned n_items);
        int unsigned start;
        int unsigned push_pct;
        int unsigned k;
        start    = sent_count;
        push_pct = $urandom_range(70, 35);
        while (sent_count - start < n_items) begin
            if ($urandom_range(99) < 5)
                push_pct = $urandom_range(85, 20);
            k = $urandom_range(99);
            if (k < push_pct)
                send_frame(pick_length());
            else if (k < push_pct + (97 - push_pct) / 2)
                send_item(make_op(fsq_pkg::OP_PEEK, 8'($urandom_range(255)),
                                  1'($urandom_range(1)), pick_offset()));
            else if (k < 97)
                send_item(make_op(fsq_pkg::OP_POP, 8'($urandom_range(255)),
                                  1'($urandom_range(1)), 8'($urandom_range(255))));
            else
                send_item(make_op(2'($urandom_range(3)), 8'($urandom_range(255)),
                                  1'($urandom_range(1)), 8'($urandom_range(255))));
        end
    endtask

    initial begin
        stim_row_t stim [$];
        foreach (shadow_len[i]) shadow_len[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty ring and unknown operation.
        stim.push_back(fixed_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h00, 0, 0, 0, 0, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00, 0, 0, 0, 0, 0));
        stim.push_back(fixed_row(OP_UNKNOWN, 8'hFF, 1'b1, 8'hFF, 0, 0, 0, 0, 0));
        // A three-byte frame, then peeks inside, at and past its end.
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'hFF, 1'b0, 8'hFF, 0, 0, 0, 0, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h00, 1'b0, 8'h00, 0, 0, 0, 0, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'hA5, 1'b1, 8'h00, 1, 3, 0, 1, 0));
        stim.push_back(op_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h00));
        stim.push_back(op_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h02));
        stim.push_back(fixed_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h03, 1, 3, 0, 1, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'hFF, 1, 3, 0, 1, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h5A, 1'b1, 8'h00, 1, 3, 0, 2, 0));
        stim.push_back(op_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00));
        stim.push_back(op_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h00));
        stim.push_back(fixed_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00, 1, 0, 0, 0, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00, 0, 0, 0, 0, 0));
        // One slot (zero clamps up) of two bytes: truncation, then a dropped frame.
        stim.push_back(cfg_row(fsq_pkg::REG_SLOTS_IN_USE, 32'd0));
        stim.push_back(cfg_row(fsq_pkg::REG_SLOT_BYTES, 32'd2));
        stim.push_back(op_row(fsq_pkg::OP_PUSH, 8'h11, 1'b0, 8'h00));
        stim.push_back(op_row(fsq_pkg::OP_PUSH, 8'h22, 1'b0, 8'h00));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h33, 1'b1, 8'h00, 1, 2, 0, 1, 0));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h44, 1'b0, 8'h00, 0, 2, 0, 1, 1));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h55, 1'b1, 8'h00, 0, 2, 0, 1, 1));
        stim.push_back(op_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h01));
        stim.push_back(fixed_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h02, 1, 2, 0, 1, 1));
        stim.push_back(fixed_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00, 1, 0, 0, 0, 1));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h66, 1'b1, 8'h00, 1, 1, 0, 1, 1));
        stim.push_back(op_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00));
        // Register values above range clamp down, a zero byte count clamps up.
        stim.push_back(cfg_row(fsq_pkg::REG_SLOTS_IN_USE, 32'd31));
        stim.push_back(cfg_row(fsq_pkg::REG_SLOT_BYTES, 32'd0));
        stim.push_back(op_row(fsq_pkg::OP_PUSH, 8'h77, 1'b0, 8'h00));
        stim.push_back(fixed_row(fsq_pkg::OP_PUSH, 8'h88, 1'b1, 8'h00, 1, 1, 0, 1, 1));
        stim.push_back(op_row(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h00));
        stim.push_back(op_row(fsq_pkg::OP_POP, 8'h00, 1'b0, 8'h00));
        stim.push_back(cfg_row(fsq_pkg::REG_SLOT_BYTES, 32'd511));

        foreach (stim[i]) begin
            if (stim[i].is_write) begin
                await_results();
                write_reg(stim[i].reg_index, stim[i].value);
            end else begin
                send_item(stim[i].xfer);
            end
        end

        // Random phases with different register settings and idle patterns.
        for (int phase = 0; phase < 3; phase++) begin
            empty_ring();
            case (phase)
                0: begin
                    write_reg(fsq_pkg::REG_SLOTS_IN_USE, 32'd16);
                    write_reg(fsq_pkg::REG_SLOT_BYTES, 32'd256);
                    // Longest slot, overfilled, then read at its last offset.
                    send_frame(fsq_pkg::MAX_SLOT_BYTES + 2);
                    send_item(make_op(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'hFF));
                    send_item(make_op(fsq_pkg::OP_PEEK, 8'h00, 1'b0, 8'h00));
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 18;
                    write_reg(fsq_pkg::REG_SLOTS_IN_USE,
                              ($urandom_range(7) == 0) ? 0 : $urandom_range(4, 1));
                    write_reg(fsq_pkg::REG_SLOT_BYTES,
                              ($urandom_range(7) == 0) ? 0 : $urandom_range(12, 1));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_reg(fsq_pkg::REG_SLOTS_IN_USE, $urandom_range(31));
                    write_reg(fsq_pkg::REG_SLOT_BYTES, $urandom_range(511));
                end
            endcase
            run_traffic(PHASE_ITEMS);
        end

        await_results();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[frame_slot_queue.f]
hw/rtl/fsq_pkg.sv
hw/rtl/fsq_frame_ram.sv
hw/rtl/frame_slot_queue.sv
tb/tb.sv
